// ===== rtl/core/rph_pkg.sv =====
// Shared types, constants and ordering function for the request priority heap.
`default_nettype none
package rph_pkg;

    localparam int Depth = 16;
    localparam int IdxW  = $clog2(Depth);
    localparam int CntW  = IdxW + 1;
    localparam int TimeW = 32;
    localparam int IdW   = 8;
    localparam int OccW  = 5;
    localparam int CapW  = 5;
    localparam int StW   = 2;

    localparam logic [StW-1:0] StOk    = 2'd0;
    localparam logic [StW-1:0] StFull  = 2'd1;
    localparam logic [StW-1:0] StEmpty = 2'd2;

    localparam logic CmdPush = 1'b0;
    localparam logic CmdPop  = 1'b1;

    localparam logic RegOrderMode = 1'b0;
    localparam logic RegCapLimit  = 1'b1;

    typedef struct packed {
        logic [TimeW-1:0] arrival;
        logic [TimeW-1:0] deadline;
        logic [IdW-1:0]   id;
    } t_entry;

    // x must sit above y in the heap
    function automatic logic ranks_before(input logic mode, input t_entry x,
                                          input t_entry y);
        logic [TimeW-1:0] kx;
        logic [TimeW-1:0] ky;
        kx = mode ? x.deadline : x.arrival;
        ky = mode ? y.deadline : y.arrival;
        if (kx != ky) begin
            return kx < ky;
        end
        return x.id < y.id;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/request_priority_heap.sv =====
// Request priority heap: binary min-heap in one synchronous memory, sifted by a sequencer.
// Push: written directly when the heap is empty, refused when full, else sifted up (one parent read per level).
// Pop: reports empty with no entries, returns the root with one entry, else sifts down (left and right child reads).
// One command at a time; o_busy is high until the result word is strobed on o_done.
// Results are strobed for one cycle and cannot be held off by the receiver.
// Synchronous active-low reset clears the count and restores order_mode 0 and capacity 16.
`default_nettype none
module request_priority_heap (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    output logic                               o_busy,
    input  wire                                i_cmd,
    input  wire  [rph_pkg::TimeW-1:0]          i_in_arrival_time,
    input  wire  [rph_pkg::TimeW-1:0]          i_in_deadline,
    input  wire  [rph_pkg::IdW-1:0]            i_in_requester_id,
    output logic                               o_done,
    output logic [rph_pkg::StW-1:0]            o_status,
    output logic                               o_out_valid,
    output logic [rph_pkg::TimeW-1:0]          o_out_arrival_time,
    output logic [rph_pkg::TimeW-1:0]          o_out_deadline,
    output logic [rph_pkg::IdW-1:0]            o_out_requester_id,
    output logic [rph_pkg::OccW-1:0]           o_occupancy,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire                                i_cfg_index,
    input  wire  [rph_pkg::CapW-1:0]           i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_UP_FIN, S_POP_ROOT, S_POP_LAST, S_DN_STEP, S_DN_L, S_DN_R
    } t_state;

    // heap memory
    rph_pkg::t_entry mem [rph_pkg::Depth];
    rph_pkg::t_entry rd_data;
    rph_pkg::t_entry wr_data;
    logic [rph_pkg::IdxW-1:0] rd_addr, wr_addr;
    logic wr_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && wr_addr == rd_addr) begin
            rd_data <= wr_data;
        end else begin
            rd_data <= mem[rd_addr];
        end
    end

    t_state r_state, n_state;
    logic [rph_pkg::CntW-1:0] r_cnt, n_cnt;
    logic [rph_pkg::IdxW-1:0] r_pos, n_pos;
    rph_pkg::t_entry r_item, n_item;
    rph_pkg::t_entry r_left, n_left;
    rph_pkg::t_entry r_root, n_root;
    logic r_mode;
    logic [rph_pkg::CapW-1:0] r_cap;
    logic r_done, n_done;
    logic [rph_pkg::StW-1:0] r_status, n_status;
    logic r_valid, n_valid;
    rph_pkg::t_entry r_out, n_out;
    logic [rph_pkg::OccW-1:0] r_occ, n_occ;

    logic accept;
    logic full;
    int unsigned lim;
    rph_pkg::t_entry in_item;
    logic [rph_pkg::IdxW-1:0] parent, grand, cnt_parent;
    logic [rph_pkg::CntW-1:0] left_idx;
    logic [rph_pkg::CntW:0] right_idx;
    rph_pkg::t_entry cand_l, best_v;
    logic l_win, r_win, up_win;

    assign o_busy      = (r_state != S_IDLE);
    // registers change only between commands
    assign o_cfg_ready = !o_busy && !i_start;
    assign accept      = i_start && !o_busy;
    assign in_item     = '{arrival: i_in_arrival_time, deadline: i_in_deadline,
                           id: i_in_requester_id};
    assign lim  = (32'(r_cap) < 32'(rph_pkg::Depth)) ? 32'(r_cap) : 32'(rph_pkg::Depth);
    assign full = (32'(r_cnt) >= lim);

    assign cnt_parent = rph_pkg::IdxW'((r_cnt - 1'b1) >> 1);
    assign parent     = rph_pkg::IdxW'((r_pos - 1'b1) >> 1);
    assign grand      = rph_pkg::IdxW'((parent - 1'b1) >> 1);
    assign left_idx   = {r_pos, 1'b1};
    assign right_idx  = {1'b0, left_idx} + 1'b1;

    assign cand_l = (r_state == S_DN_R) ? r_left : rd_data;
    assign l_win  = rph_pkg::ranks_before(r_mode, cand_l, r_item);
    assign best_v = l_win ? cand_l : r_item;
    assign r_win  = (r_state == S_DN_R) && rph_pkg::ranks_before(r_mode, rd_data, best_v);
    assign up_win = rph_pkg::ranks_before(r_mode, r_item, rd_data);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_item   = r_item;
        n_left   = r_left;
        n_root   = r_root;
        n_done   = 1'b0;
        n_status = r_status;
        n_valid  = r_valid;
        n_out    = r_out;
        n_occ    = r_occ;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_item;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_done   = 1'b1;
                    n_status = rph_pkg::StOk;
                    n_valid  = 1'b0;
                    n_out    = '0;
                    n_occ    = rph_pkg::OccW'(r_cnt);
                    if (i_cmd == rph_pkg::CmdPush) begin
                        if (full) begin
                            n_status = rph_pkg::StFull;
                        end else begin
                            n_cnt  = r_cnt + 1'b1;
                            n_occ  = rph_pkg::OccW'(r_cnt + 1'b1);
                            n_item = in_item;
                            n_pos  = rph_pkg::IdxW'(r_cnt);
                            if (r_cnt == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = in_item;
                            end else begin
                                n_done  = 1'b0;
                                rd_addr = cnt_parent;
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = rph_pkg::StEmpty;
                        end else begin
                            n_done  = 1'b0;
                            rd_addr = '0;
                            n_state = S_POP_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                wr_en = 1'b1;
                if (up_win) begin
                    wr_data = rd_data;
                    n_pos   = parent;
                    rd_addr = grand;
                    n_state = (parent == '0) ? S_UP_FIN : S_UP;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_UP_FIN: begin
                wr_en   = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_POP_ROOT: begin
                n_root  = rd_data;
                n_cnt   = r_cnt - 1'b1;
                rd_addr = rph_pkg::IdxW'(r_cnt - 1'b1);
                if (r_cnt == rph_pkg::CntW'(1)) begin
                    n_done   = 1'b1;
                    n_status = rph_pkg::StOk;
                    n_valid  = 1'b1;
                    n_out    = rd_data;
                    n_occ    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_POP_LAST;
                end
            end
            S_POP_LAST: begin
                n_item  = rd_data;
                n_pos   = '0;
                n_state = S_DN_STEP;
            end
            S_DN_STEP: begin
                if (left_idx < r_cnt) begin
                    rd_addr = left_idx[rph_pkg::IdxW-1:0];
                    n_state = S_DN_L;
                end else begin
                    wr_en   = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DN_L, S_DN_R: begin
                n_left = cand_l;
                if (r_state == S_DN_L && right_idx < {1'b0, r_cnt}) begin
                    rd_addr = right_idx[rph_pkg::IdxW-1:0];
                    n_state = S_DN_R;
                end else begin
                    wr_en = 1'b1;
                    if (r_win) begin
                        wr_data = rd_data;
                        n_pos   = right_idx[rph_pkg::IdxW-1:0];
                        n_state = S_DN_STEP;
                    end else if (l_win) begin
                        wr_data = cand_l;
                        n_pos   = left_idx[rph_pkg::IdxW-1:0];
                        n_state = S_DN_STEP;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // pop completion from the sift-down states
        if (n_done && (r_state == S_DN_STEP || r_state == S_DN_L || r_state == S_DN_R)) begin
            n_status = rph_pkg::StOk;
            n_valid  = 1'b1;
            n_out    = r_root;
            n_occ    = rph_pkg::OccW'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mode  <= 1'b0;
            r_cap   <= rph_pkg::CapW'(16);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rph_pkg::RegOrderMode: r_mode <= i_cfg_data[0];
                    rph_pkg::RegCapLimit:  r_cap  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_pos    <= n_pos;
        r_item   <= n_item;
        r_left   <= n_left;
        r_root   <= n_root;
        r_status <= n_status;
        r_valid  <= n_valid;
        r_out    <= n_out;
        r_occ    <= n_occ;
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_out_valid        = r_valid;
    assign o_out_arrival_time = r_out.arrival;
    assign o_out_deadline     = r_out.deadline;
    assign o_out_requester_id = r_out.id;
    assign o_occupancy        = r_occ;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(rph_pkg::Depth))
        else $error("entry count above depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobed while sequencer busy");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == rph_pkg::CmdPush && full)
        |=> (o_done && o_status == rph_pkg::StFull && $stable(r_cnt)))
        else $error("refused push not reported next cycle");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == rph_pkg::StEmpty) |-> (o_occupancy == '0 && !o_out_valid))
        else $error("empty pop with nonzero occupancy");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for request_priority_heap: directed and random push/pop traffic against a heap model.
`timescale 1ns / 1ps

package heap_check_pkg;
    import rph_pkg::*;

    typedef struct packed {
        logic [StW-1:0]   status;
        logic             valid;
        logic [TimeW-1:0] arrival;
        logic [TimeW-1:0] deadline;
        logic [IdW-1:0]   id;
        logic [OccW-1:0]  occupancy;
    } t_heap_reply;

    class heap_scoreboard;
        t_entry      slots [Depth];
        int unsigned held;
        logic        by_deadline;
        int unsigned cap_limit;
        t_heap_reply replies_due [$];
        int unsigned errors;

        function new();
            held        = 0;
            by_deadline = 1'b0;
            cap_limit   = 16;
            errors      = 0;
        endfunction

        function void set_register(logic idx, logic [CapW-1:0] data);
            if (idx == RegOrderMode) begin
                by_deadline = data[0];
            end else begin
                cap_limit = data;
            end
        endfunction

        // x belongs above y under the current mode
        function bit outranks(t_entry x, t_entry y);
            logic [TimeW-1:0] kx;
            logic [TimeW-1:0] ky;
            kx = by_deadline ? x.deadline : x.arrival;
            ky = by_deadline ? y.deadline : y.arrival;
            if (kx != ky) begin
                return kx < ky;
            end
            return x.id < y.id;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            t_entry t;
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        // Apply one command to the heap copy and queue the word it must produce.
        function void note_command(logic cmd, t_entry req);
            t_heap_reply r;
            int unsigned lim;
            int unsigned pos;
            int unsigned up;
            int unsigned best;
            int unsigned lc;
            int unsigned rc;
            r   = '0;
            lim = (cap_limit < Depth) ? cap_limit : Depth;
            if (cmd == CmdPush) begin
                if (held >= lim) begin
                    r.status = StFull;
                end else begin
                    pos        = held;
                    slots[pos] = req;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!outranks(slots[pos], slots[up])) begin
                            break;
                        end
                        swap_slots(pos, up);
                        pos = up;
                    end
                    held = held + 1;
                end
            end else if (held == 0) begin
                r.status = StEmpty;
            end else begin
                r.status   = StOk;
                r.valid    = 1'b1;
                r.arrival  = slots[0].arrival;
                r.deadline = slots[0].deadline;
                r.id       = slots[0].id;
                held       = held - 1;
                if (held > 0) begin
                    slots[0] = slots[held];
                    pos      = 0;
                    while (1) begin
                        best = pos;
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        if (lc < held && outranks(slots[lc], slots[best])) begin
                            best = lc;
                        end
                        if (rc < held && outranks(slots[rc], slots[best])) begin
                            best = rc;
                        end
                        if (best == pos) begin
                            break;
                        end
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
            end
            r.occupancy = held[OccW-1:0];
            replies_due.push_back(r);
        endfunction

        function void compare(string field, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_heap_reply got);
            t_heap_reply want;
            if (replies_due.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            want = replies_due.pop_front();
            compare("status", TimeW'(want.status), TimeW'(got.status));
            compare("out_valid", TimeW'(want.valid), TimeW'(got.valid));
            compare("out_arrival_time", want.arrival, got.arrival);
            compare("out_deadline", want.deadline, got.deadline);
            compare("out_requester_id", TimeW'(want.id), TimeW'(got.id));
            compare("occupancy", TimeW'(want.occupancy), TimeW'(got.occupancy));
        endfunction
    endclass
endpackage

module tb;
    import rph_pkg::*;
    import heap_check_pkg::*;

    localparam int DogLimit     = 2000;
    localparam int SettleCycles = 24;
    localparam int RandomPhases = 22;
    localparam int PhaseItems   = 50;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_start           = 1'b0;
    logic              i_cmd             = CmdPush;
    logic [TimeW-1:0]  i_in_arrival_time = '0;
    logic [TimeW-1:0]  i_in_deadline     = '0;
    logic [IdW-1:0]    i_in_requester_id = '0;
    logic              i_cfg_valid       = 1'b0;
    logic              i_cfg_index       = RegOrderMode;
    logic [CapW-1:0]   i_cfg_data        = '0;
    logic              o_busy;
    logic              o_done;
    logic [StW-1:0]    o_status;
    logic              o_out_valid;
    logic [TimeW-1:0]  o_out_arrival_time;
    logic [TimeW-1:0]  o_out_deadline;
    logic [IdW-1:0]    o_out_requester_id;
    logic [OccW-1:0]   o_occupancy;
    logic              o_cfg_ready;

    heap_scoreboard sb;
    int unsigned    quiet_cycles = 0;
    bit             no_idle      = 1'b0;

    request_priority_heap dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_cmd              (i_cmd),
        .i_in_arrival_time  (i_in_arrival_time),
        .i_in_deadline      (i_in_deadline),
        .i_in_requester_id  (i_in_requester_id),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_out_valid        (o_out_valid),
        .o_out_arrival_time (o_out_arrival_time),
        .o_out_deadline     (o_out_deadline),
        .o_out_requester_id (o_out_requester_id),
        .o_occupancy        (o_occupancy),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_command(i_cmd, {i_in_arrival_time, i_in_deadline, i_in_requester_id});
            end
            if (o_done) begin
                sb.check_reply({o_status, o_out_valid, o_out_arrival_time, o_out_deadline,
                                o_out_requester_id, o_occupancy});
            end
            if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles + 1 >= DogLimit) begin
                $display("tb failed");
                $finish;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
    end

    function automatic t_entry request_of(logic [TimeW-1:0] a, logic [TimeW-1:0] d,
                                          logic [IdW-1:0] id);
        t_entry e;
        e.arrival  = a;
        e.deadline = d;
        e.id       = id;
        return e;
    endfunction

    // small values often, to force key ties
    function automatic logic [TimeW-1:0] random_stamp();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return TimeW'($urandom_range(0, 7));
            default: return TimeW'($urandom());
        endcase
    endfunction

    function automatic t_entry random_request();
        logic [IdW-1:0] id;
        id = ($urandom_range(0, 2) == 0) ? IdW'($urandom_range(0, 255))
                                         : IdW'($urandom_range(0, 3));
        return request_of(random_stamp(), random_stamp(), id);
    endfunction

    function automatic logic [CapW-1:0] random_cap();
        case ($urandom_range(0, 7))
            0:       return CapW'(0);
            1:       return CapW'(1);
            2:       return CapW'(31);
            3:       return CapW'($urandom_range(17, 31));
            4:       return CapW'($urandom_range(2, 15));
            default: return CapW'(16);
        endcase
    endfunction

    task automatic issue(logic cmd, t_entry req);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_cmd             <= cmd;
        i_in_arrival_time <= req.arrival;
        i_in_deadline     <= req.deadline;
        i_in_requester_id <= req.id;
        do @(posedge i_clk); while (!(i_start && !o_busy));
    endtask

    task automatic settle();
        i_start <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CapW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_register(idx, data);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned push_pct;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(CmdPop, random_request());
        issue(CmdPush, request_of('1, '0, 8'hFF));
        issue(CmdPush, request_of('0, '1, 8'h00));
        issue(CmdPush, request_of(32'd7, 32'd9, 8'd4));
        issue(CmdPush, request_of(32'd7, 32'd9, 8'd3));
        issue(CmdPop, random_request());
        issue(CmdPop, random_request());

        // switch to deadline order with entries held
        settle();
        write_reg(RegOrderMode, CapW'(1));
        issue(CmdPush, request_of(32'd9, '0, 8'd2));
        issue(CmdPop, random_request());

        // limit zero (below occupancy), then limit one
        settle();
        write_reg(RegCapLimit, CapW'(0));
        issue(CmdPush, random_request());
        issue(CmdPop, random_request());
        settle();
        write_reg(RegCapLimit, CapW'(1));
        issue(CmdPush, random_request());
        issue(CmdPop, random_request());
        issue(CmdPush, random_request());
        issue(CmdPush, random_request());
        issue(CmdPop, random_request());
        issue(CmdPop, random_request());

        settle();
        write_reg(RegCapLimit, CapW'(31));
        write_reg(RegOrderMode, CapW'(0));

        for (int ph = 0; ph < RandomPhases; ph++) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 25;
                1:       push_pct = 50;
                2:       push_pct = 70;
                default: push_pct = 90;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PhaseItems; n++) begin
                issue(($urandom_range(1, 100) <= push_pct) ? CmdPush : CmdPop, random_request());
            end
            settle();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(RegOrderMode, CapW'($urandom_range(0, 31)));
            end
            write_reg(RegCapLimit, random_cap());
        end

        settle();
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// ===== request_priority_heap.f =====
rtl/core/rph_pkg.sv
rtl/core/request_priority_heap.sv
test/tb.sv
